// ----- rtl/msi_pkg.sv -----
// Package for the multidimensional index stepper.
// Holds the step mode and register index codes and the fixed geometry.
// No dependencies.
package msi_pkg;

  // Fixed geometry of the index: four coordinates of sixteen bits.
  localparam int unsigned NUM_DIMS = 4;
  localparam int unsigned COORD_W  = 16;
  localparam int unsigned CFG_W    = 64;

  typedef logic [COORD_W-1:0] coord_t;

  // Step modes as written to the step_mode register.
  typedef enum logic [2:0] {
    STEP_INCR     = 3'd0,
    STEP_DECR     = 3'd1,
    STEP_INCR_REV = 3'd2,
    STEP_DECR_REV = 3'd3,
    STEP_MASKED   = 3'd4,
    STEP_BOUNDED  = 3'd5
  } step_mode_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_DIM_COUNT    = 3'd0,
    CFG_STEP_MODE    = 3'd1,
    CFG_DIM_SIZES    = 3'd2,
    CFG_MASK_BITS    = 3'd3,
    CFG_LOWER_BOUNDS = 3'd4,
    CFG_UPPER_BOUNDS = 3'd5
  } cfg_idx_e;

  // Control shared by every cell of the row.
  typedef struct packed {
    logic       en;        // a request is accepted this cycle
    logic       load;      // the request is a load
    step_mode_e mode;      // active step mode
    logic       all_zero;  // all active coordinates are zero
  } cell_ctrl_t;

endpackage

// ----- rtl/msi_cell.sv -----
// One coordinate cell of the index stepper row.
// Holds one coordinate and passes forward and reverse carries to its neighbors.
// Depends on msi_pkg.
module msi_cell import msi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       active_i,
  input  logic       mask_i,
  input  coord_t     size_i,
  input  coord_t     lo_i,
  input  coord_t     hi_i,
  input  coord_t     load_val_i,
  input  logic       fwd_cin_i,
  input  logic       rev_cin_i,
  output logic       fwd_cout_o,
  output logic       rev_cout_o,
  output logic       nz_o,
  output coord_t     coord_o
);

  coord_t           coord_q, coord_d;
  logic [COORD_W:0] inc;
  coord_t           size_m1;
  logic             carry;
  logic             pass;
  logic             rev;

  assign inc     = {1'b0, coord_q} + {{COORD_W{1'b0}}, 1'b1};
  // A size of zero counts as one, so its last position is zero.
  assign size_m1 = (size_i == '0) ? '0 : size_i - coord_t'(1);
  assign rev     = (ctrl_i.mode == STEP_INCR_REV) || (ctrl_i.mode == STEP_DECR_REV);
  assign carry   = rev ? rev_cin_i : fwd_cin_i;

  // Pass condition: a carry that reaches this cell moves on to the next one.
  always_comb begin
    pass = 1'b0;
    if (!active_i) begin
      pass = 1'b1;
    end else begin
      unique case (ctrl_i.mode)
        STEP_INCR, STEP_INCR_REV: pass = (inc >= {1'b0, size_m1} + 1'b1);
        STEP_MASKED:  pass = mask_i || (inc >= {1'b0, size_m1} + 1'b1);
        STEP_BOUNDED: pass = (lo_i == hi_i) || (inc > {1'b0, hi_i});
        STEP_DECR, STEP_DECR_REV: pass = (coord_q == '0);
        default: pass = 1'b0;
      endcase
    end
  end

  assign fwd_cout_o = fwd_cin_i & pass;
  assign rev_cout_o = rev_cin_i & pass;
  assign nz_o       = active_i && (coord_q != '0);
  assign coord_o    = coord_q;

  // Next coordinate for a load or a step.
  always_comb begin
    coord_d = coord_q;
    if (ctrl_i.load) begin
      coord_d = load_val_i;
    end else if (active_i) begin
      unique case (ctrl_i.mode)
        STEP_INCR, STEP_INCR_REV: begin
          if (carry) coord_d = pass ? '0 : inc[COORD_W-1:0];
        end
        STEP_MASKED: begin
          if (carry && !mask_i) coord_d = pass ? '0 : inc[COORD_W-1:0];
        end
        STEP_BOUNDED: begin
          if (carry && (lo_i != hi_i)) coord_d = pass ? lo_i : inc[COORD_W-1:0];
        end
        STEP_DECR, STEP_DECR_REV: begin
          if (ctrl_i.all_zero) begin
            coord_d = size_m1;
          end else if (carry) begin
            coord_d = pass ? size_m1 : coord_q - coord_t'(1);
          end
        end
        default: coord_d = coord_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coord_q <= '0;
    end else if (ctrl_i.en) begin
      coord_q <= coord_d;
    end
  end

endmodule

// ----- rtl/multidim_index_stepper_top.sv -----
// Top level of the multidimensional index stepper.
// Holds the configuration registers and the row of msi_cell instances.
// Depends on msi_pkg and msi_cell.
//
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one request per item:
//   action_i = 1 loads the index from load_coord0_i..load_coord3_i, action_i = 0
//   steps it in the mode held in the step_mode register.
//   The output channel (out_valid_o / out_stall_i) returns one result per
//   request: the index after the request on coord0_o..coord3_o and the more_o
//   flag, which drops to 0 when a step wraps the whole sequence.
//   The result is registered and shown in the cycle after acceptance.
//   One request is taken per cycle while the output is not stalled; the carry
//   runs through the four cells in the same cycle, which sets the clock period.
//   A new request is taken in the same cycle in which the pending result is
//   taken. While the receiver stalls a pending result, in_stall_o is high and
//   the index holds.
//   Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i while
//   no request is in flight.
//   Reset clears the index to all zeros, empties the output and loads the
//   register defaults: one dimension, incrementing, all sizes one.
module multidim_index_stepper_top import msi_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             action_i,
  input  coord_t           load_coord0_i,
  input  coord_t           load_coord1_i,
  input  coord_t           load_coord2_i,
  input  coord_t           load_coord3_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output coord_t           coord0_o,
  output coord_t           coord1_o,
  output coord_t           coord2_o,
  output coord_t           coord3_o,
  output logic             more_o
);

  logic [2:0]             dim_count_q;
  step_mode_e             step_mode_q;
  logic [CFG_W-1:0]       dim_sizes_q;
  logic [NUM_DIMS-1:0]    mask_bits_q;
  logic [CFG_W-1:0]       lower_bounds_q;
  logic [CFG_W-1:0]       upper_bounds_q;

  logic                   out_valid_q;
  logic                   more_q, more_d;
  logic                   accept;
  cell_ctrl_t             ctrl;

  logic [NUM_DIMS:0]      fwd_c;
  logic [NUM_DIMS:0]      rev_c;
  logic [NUM_DIMS-1:0]    nz;
  coord_t                 load_val [NUM_DIMS];
  coord_t                 coord    [NUM_DIMS];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q    <= 3'd1;
      step_mode_q    <= STEP_INCR;
      dim_sizes_q    <= 64'h0001_0001_0001_0001;
      mask_bits_q    <= '0;
      lower_bounds_q <= '0;
      upper_bounds_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DIM_COUNT:    dim_count_q    <= cfg_data_i[2:0];
        CFG_STEP_MODE:    step_mode_q    <= step_mode_e'(cfg_data_i[2:0]);
        CFG_DIM_SIZES:    dim_sizes_q    <= cfg_data_i;
        CFG_MASK_BITS:    mask_bits_q    <= cfg_data_i[NUM_DIMS-1:0];
        CFG_LOWER_BOUNDS: lower_bounds_q <= cfg_data_i;
        CFG_UPPER_BOUNDS: upper_bounds_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: take a request whenever the output is free or being taken.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  assign ctrl.en       = accept;
  assign ctrl.load     = action_i;
  assign ctrl.mode     = step_mode_q;
  assign ctrl.all_zero = (nz == '0);

  assign load_val[0] = load_coord0_i;
  assign load_val[1] = load_coord1_i;
  assign load_val[2] = load_coord2_i;
  assign load_val[3] = load_coord3_i;

  // Carry chains: forward enters at dimension 0, reverse at the top cell.
  // Inactive cells pass both carries through.
  assign fwd_c[0]        = 1'b1;
  assign rev_c[NUM_DIMS] = 1'b1;

  for (genvar d = 0; d < NUM_DIMS; d++) begin : g_cell
    logic active;
    assign active = (d == 0) || (dim_count_q > 3'(d));

    msi_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .active_i   (active),
      .mask_i     (mask_bits_q[d]),
      .size_i     (dim_sizes_q[d*COORD_W +: COORD_W]),
      .lo_i       (lower_bounds_q[d*COORD_W +: COORD_W]),
      .hi_i       (upper_bounds_q[d*COORD_W +: COORD_W]),
      .load_val_i (load_val[d]),
      .fwd_cin_i  (fwd_c[d]),
      .rev_cin_i  (rev_c[d+1]),
      .fwd_cout_o (fwd_c[d+1]),
      .rev_cout_o (rev_c[d]),
      .nz_o       (nz[d]),
      .coord_o    (coord[d])
    );
  end

  // More flag drops when a step wraps: carry out, or decrement from all zero.
  always_comb begin
    more_d = 1'b1;
    if (!action_i) begin
      unique case (step_mode_q)
        STEP_INCR, STEP_MASKED, STEP_BOUNDED: more_d = ~fwd_c[NUM_DIMS];
        STEP_INCR_REV:                        more_d = ~rev_c[0];
        STEP_DECR, STEP_DECR_REV:             more_d = ~ctrl.all_zero;
        default:                              more_d = 1'b1;
      endcase
    end
  end

  // Output status register; the coordinates come straight from the cells.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      more_q      <= 1'b1;
    end else begin
      if (accept) begin
        out_valid_q <= 1'b1;
        more_q      <= more_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign more_o      = more_q;
  assign coord0_o    = coord[0];
  assign coord1_o    = coord[1];
  assign coord2_o    = coord[2];
  assign coord3_o    = coord[3];

endmodule

// ----- rtl/msi_checker.sv -----
// Port-level checker for the multidimensional index stepper.
// Watches the top level's ports only; bound to multidim_index_stepper_top.
// Depends on msi_pkg.
module msi_checker import msi_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             action_i,
  input coord_t           load_coord0_i,
  input coord_t           load_coord3_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input coord_t           coord0_o,
  input coord_t           coord3_o,
  input logic             more_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Every accepted request yields a result in the next cycle.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted request produced no result");

  // The input is held back only by a stalled pending result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a pending stalled result");

  // A load shows its first and last coordinates and a set more flag.
  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i |=>
      coord0_o == $past(load_coord0_i) && coord3_o == $past(load_coord3_i) && more_o)
    else $error("load result mismatch");

endmodule

bind multidim_index_stepper_top msi_checker u_msi_checker (.*);
